### hdl/ccp_pkg.sv
// ----------------------------------------------------------------------------
// Circle canvas painter package
// Canvas geometry, fixed-point widths, item codes and stream field offsets.
// ----------------------------------------------------------------------------
package ccp_pkg;

    // canvas geometry
    localparam int MAX_SIDE     = 256;
    localparam int SIDE_BITS    = $clog2(MAX_SIDE);
    localparam int SIDE_W       = SIDE_BITS + 1;
    localparam int CANVAS_DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W       = 2 * SIDE_BITS;
    localparam int CHAR_W       = 8;

    // fixed-point coordinates
    localparam int FRAC_BITS = 8;
    localparam int COORD_W   = 20;
    localparam int POS_W     = SIDE_BITS + FRAC_BITS;
    localparam int DIFF_W    = ((POS_W > COORD_W) ? POS_W : COORD_W) + 1;
    localparam int MAG_W     = DIFF_W;
    localparam int SQ_W      = 2 * MAG_W;
    localparam int SUM_W     = SQ_W + 1;
    localparam logic [MAG_W-1:0] ONE_FIX = MAG_W'(1) << FRAC_BITS;

    // item kinds; the fourth code is unused
    typedef enum logic [1:0] {
        KIND_CLEAR = 2'd0,
        KIND_DRAW  = 2'd1,
        KIND_READ  = 2'd2
    } kind_t;

    localparam logic [7:0] SHAPE_OUTLINE = 8'h63;   // 'c'
    localparam logic [7:0] SHAPE_FILLED  = 8'h43;   // 'C'

    // configuration registers
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = SIDE_W;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BG     = 2'd2;
    localparam logic [SIDE_W-1:0] SIDE_RST = SIDE_W'(MAX_SIDE);
    localparam logic [CHAR_W-1:0] BG_RST   = 8'd32;

    // input tdata layout
    localparam int SHAPE_LSB  = 0;
    localparam int CX_LSB     = SHAPE_LSB + 8;
    localparam int CY_LSB     = CX_LSB + COORD_W;
    localparam int RAD_LSB    = CY_LSB + COORD_W;
    localparam int PAINT_LSB  = RAD_LSB + COORD_W;
    localparam int COL_LSB    = PAINT_LSB + CHAR_W;
    localparam int ROW_LSB    = COL_LSB + 8;
    localparam int IN_USED_W  = ROW_LSB + 8;
    localparam int IN_DATA_W  = ((IN_USED_W + 7) / 8) * 8;
    localparam int KIND_W     = 2;
    localparam int OUT_DATA_W = CHAR_W;

endpackage

### hdl/ccp_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ccp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hdl/circle_canvas_painter_unit.sv
// ----------------------------------------------------------------------------
// Circle canvas painter
// Byte canvas in block RAM; clears, paints circle outlines or discs, reads.
// ----------------------------------------------------------------------------
// One item is in work at a time and each gives one result. A clear or draw
// item sweeps the used area (width x height after saturation to 256) one
// pixel per cycle through the single canvas write port. A draw passes a
// setup state first; a rejected draw or an empty area skips the sweep. A
// read item does one RAM read, or none when off the used area. Canvas
// contents are unknown after reset until a clear item has written them;
// there is no clearing pass. The next item is taken while the last result
// still waits.
module circle_canvas_painter_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration
    input  logic                             cfg_we,
    input  logic [ccp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ccp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // item stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // shape_type, center_x, center_y, radius, paint_char, pixel_col, pixel_row
    input  logic [ccp_pkg::IN_DATA_W-1:0]    s_tdata,
    // kind
    input  logic [ccp_pkg::KIND_W-1:0]       s_tuser,
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // pixel_value
    output logic [ccp_pkg::OUT_DATA_W-1:0]   m_tdata,
    // status
    output logic [0:0]                       m_tuser
);

    import ccp_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SWEEP,
        ST_DRAIN,
        ST_READ,
        ST_RESULT
    } state_t;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [SIDE_W-1:0] width_reg;
    logic [SIDE_W-1:0] height_reg;
    logic [CHAR_W-1:0] bg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SIDE_RST;
            height_reg <= SIDE_RST;
            bg_reg     <= BG_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WIDTH:  width_reg  <= cfg_wdata;
                CFG_HEIGHT: height_reg <= cfg_wdata;
                CFG_BG:     bg_reg     <= cfg_wdata[CHAR_W-1:0];
                default:    ;
            endcase
        end
    end

    logic [SIDE_W-1:0]    w_used;
    logic [SIDE_W-1:0]    h_used;
    logic [SIDE_W-1:0]    w_m1;
    logic [SIDE_W-1:0]    h_m1;
    logic [SIDE_BITS-1:0] w_last;
    logic [SIDE_BITS-1:0] h_last;
    logic                 area_empty;

    assign w_used     = (width_reg > SIDE_RST) ? SIDE_RST : width_reg;
    assign h_used     = (height_reg > SIDE_RST) ? SIDE_RST : height_reg;
    assign w_m1       = w_used - SIDE_W'(1);
    assign h_m1       = h_used - SIDE_W'(1);
    assign w_last     = w_m1[SIDE_BITS-1:0];
    assign h_last     = h_m1[SIDE_BITS-1:0];
    assign area_empty = (w_used == '0) || (h_used == '0);

    // ------------------------------------------------------------------
    // input fields
    // ------------------------------------------------------------------
    logic [7:0]                 in_shape;
    logic signed [COORD_W-1:0]  in_cx;
    logic signed [COORD_W-1:0]  in_cy;
    logic signed [COORD_W-1:0]  in_rad;
    logic [CHAR_W-1:0]          in_paint;
    logic [SIDE_BITS-1:0]       in_col;
    logic [SIDE_BITS-1:0]       in_row;
    logic                       shape_ok;
    logic                       read_hit;
    logic                       s_accept;

    assign in_shape = s_tdata[SHAPE_LSB +: 8];
    assign in_cx    = signed'(s_tdata[CX_LSB +: COORD_W]);
    assign in_cy    = signed'(s_tdata[CY_LSB +: COORD_W]);
    assign in_rad   = signed'(s_tdata[RAD_LSB +: COORD_W]);
    assign in_paint = s_tdata[PAINT_LSB +: CHAR_W];
    assign in_col   = s_tdata[COL_LSB +: SIDE_BITS];
    assign in_row   = s_tdata[ROW_LSB +: SIDE_BITS];
    assign shape_ok = (in_shape == SHAPE_OUTLINE) || (in_shape == SHAPE_FILLED);
    assign read_hit = ({1'b0, in_col} < w_used) && ({1'b0, in_row} < h_used);

    // ------------------------------------------------------------------
    // control
    // ------------------------------------------------------------------
    state_t               state_reg, state_next;
    logic [SIDE_BITS-1:0] sweep_col_reg, sweep_col_next;
    logic [SIDE_BITS-1:0] sweep_row_reg, sweep_row_next;
    logic                 v1_reg, v2_reg;
    logic [CHAR_W-1:0]    res_pix_reg, res_pix_next;
    logic                 res_status_reg, res_status_next;
    logic                 m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0]    m_pix_reg, m_pix_next;
    logic                 m_status_reg, m_status_next;
    logic                 issue;
    logic                 out_free;
    logic                 rd_en;
    logic [CHAR_W-1:0]    rd_data;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign issue    = (state_reg == ST_SWEEP);
    assign out_free = !m_valid_reg || m_tready;
    assign rd_en    = s_accept && (s_tuser == KIND_READ) && read_hit;

    always_comb
    begin
        state_next      = state_reg;
        sweep_col_next  = sweep_col_reg;
        sweep_row_next  = sweep_row_reg;
        res_pix_next    = res_pix_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_pix_next      = m_pix_reg;
        m_status_next   = m_status_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    res_pix_next    = '0;
                    res_status_next = 1'b0;
                    unique case (s_tuser)
                        KIND_CLEAR:
                        begin
                            state_next = area_empty ? ST_RESULT : ST_SWEEP;
                        end
                        KIND_DRAW:
                        begin
                            if ((in_rad <= 0) || !shape_ok)
                            begin
                                res_status_next = 1'b1;
                                state_next      = ST_RESULT;
                            end
                            else
                            begin
                                state_next = area_empty ? ST_RESULT : ST_SETUP;
                            end
                        end
                        KIND_READ:
                        begin
                            state_next = read_hit ? ST_READ : ST_RESULT;
                        end
                        default:
                        begin
                            state_next = ST_RESULT;
                        end
                    endcase
                end
            end
            ST_SETUP:
            begin
                state_next = ST_SWEEP;
            end
            ST_SWEEP:
            begin
                if (sweep_col_reg == w_last)
                begin
                    sweep_col_next = '0;
                    if (sweep_row_reg == h_last)
                    begin
                        sweep_row_next = '0;
                        state_next     = ST_DRAIN;
                    end
                    else
                    begin
                        sweep_row_next = sweep_row_reg + 1'b1;
                    end
                end
                else
                begin
                    sweep_col_next = sweep_col_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                // hold until the last pixel write has left the pipeline
                if (!v1_reg && !v2_reg)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_READ:
            begin
                res_pix_next = rd_data;
                state_next   = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_pix_next    = res_pix_reg;
                    m_status_next = res_status_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            sweep_col_reg  <= '0;
            sweep_row_reg  <= '0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            res_pix_reg    <= '0;
            res_status_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            m_pix_reg      <= '0;
            m_status_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sweep_col_reg  <= sweep_col_next;
            sweep_row_reg  <= sweep_row_next;
            v1_reg         <= issue;
            v2_reg         <= v1_reg;
            res_pix_reg    <= res_pix_next;
            res_status_reg <= res_status_next;
            m_valid_reg    <= m_valid_next;
            m_pix_reg      <= m_pix_next;
            m_status_reg   <= m_status_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_pix_reg;
    assign m_tuser  = m_status_reg;

    // ------------------------------------------------------------------
    // item and sweep datapath
    // ------------------------------------------------------------------
    logic signed [COORD_W-1:0] cx_reg, cy_reg, rad_reg;
    logic [CHAR_W-1:0]         color_reg;
    logic                      filled_reg, clear_reg;
    logic [SQ_W-1:0]           outer_reg, inner_reg;
    logic                      has_inner_reg;
    logic [MAG_W-1:0]          ax1_reg, ay1_reg;
    logic [ADDR_W-1:0]         addr1_reg, addr2_reg;
    logic [SQ_W-1:0]           dx2_reg, dy2_reg;
    logic [MAG_W-1:0]          rad_mag;
    logic [MAG_W-1:0]          inner_mag;

    // radius is known positive here
    assign rad_mag   = MAG_W'(rad_reg[COORD_W-2:0]);
    assign inner_mag = rad_mag - ONE_FIX;

    function automatic logic [MAG_W-1:0] dist_mag(
        input logic [SIDE_BITS-1:0]    p,
        input logic signed [COORD_W-1:0] c
    );
        logic signed [DIFF_W-1:0] pos_s;
        logic signed [DIFF_W-1:0] c_s;
        logic signed [DIFF_W-1:0] d;
        pos_s = signed'(DIFF_W'({p, {FRAC_BITS{1'b0}}}));
        c_s   = DIFF_W'(c);
        d     = pos_s - c_s;
        return d[DIFF_W-1] ? MAG_W'(-d) : MAG_W'(d);
    endfunction

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            cx_reg     <= in_cx;
            cy_reg     <= in_cy;
            rad_reg    <= in_rad;
            color_reg  <= in_paint;
            filled_reg <= (in_shape == SHAPE_FILLED);
            clear_reg  <= (s_tuser == KIND_CLEAR);
        end
        if (state_reg == ST_SETUP)
        begin
            outer_reg     <= rad_mag * rad_mag;
            inner_reg     <= inner_mag * inner_mag;
            has_inner_reg <= (rad_mag > ONE_FIX);
        end
        if (issue)
        begin
            ax1_reg   <= dist_mag(sweep_col_reg, cx_reg);
            ay1_reg   <= dist_mag(sweep_row_reg, cy_reg);
            addr1_reg <= {sweep_row_reg, sweep_col_reg};
        end
        if (v1_reg)
        begin
            dx2_reg   <= ax1_reg * ax1_reg;
            dy2_reg   <= ay1_reg * ay1_reg;
            addr2_reg <= addr1_reg;
        end
    end

    // classify: outside beyond the radius, inside below radius minus one
    logic [SUM_W-1:0]  d2;
    logic              beyond, core, paint;
    logic              ram_we;
    logic [CHAR_W-1:0] ram_wdata;

    assign d2        = SUM_W'(dx2_reg) + SUM_W'(dy2_reg);
    assign beyond    = d2 > SUM_W'(outer_reg);
    assign core      = has_inner_reg && (d2 < SUM_W'(inner_reg));
    assign paint     = !beyond && (!core || filled_reg);
    assign ram_we    = v2_reg && (clear_reg || paint);
    assign ram_wdata = clear_reg ? bg_reg : color_reg;

    ccp_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (CANVAS_DEPTH)
    ) u_canvas (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr2_reg),
        .wdata (ram_wdata),
        .re    (rd_en),
        .raddr ({in_row, in_col}),
        .rdata (rd_data)
    );

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_no_write_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !ram_we)
        else $error("canvas write while taking a new item");

    a_read_follows: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |=> (state_reg == ST_READ))
        else $error("canvas read not followed by read state");

    a_sweep_home: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (sweep_col_reg == '0) && (sweep_row_reg == '0))
        else $error("sweep position not back at origin while idle");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
        else $error("rejected draw with nonzero pixel value");

endmodule

### tb/circle_canvas_painter_unit_tb.sv
// ----------------------------------------------------------------------------
// Circle canvas painter testbench
// Drives clear, draw and read transfers, with bad and unused codes mixed in,
// under several canvas sizes. A behavioral copy of the canvas predicts every
// result and each result is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module circle_canvas_painter_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ccp_pkg::*;

    localparam int         FIX           = 1 << FRAC_BITS;
    localparam longint     FIX_ONE       = longint'(1) << FRAC_BITS;
    localparam logic [1:0] KIND_UNUSED   = 2'd3;
    localparam logic       STATUS_OK     = 1'b0;
    localparam logic       STATUS_REJECT = 1'b1;

    typedef struct {
        logic [1:0]                kind;
        logic [7:0]                shape;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] rad;
        logic [CHAR_W-1:0]         paint;
        logic [7:0]                col;
        logic [7:0]                row;
    } canvas_item_t;

    typedef struct {
        logic [CHAR_W-1:0] pix;
        logic              status;
    } canvas_result_t;

    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        canvas_item_t          item;
        bit                    typed;
        canvas_result_t        want;
    } directed_row_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata   = '0;
    logic [KIND_W-1:0]      s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic [0:0]             m_tuser;

    // canvas copy and its registers
    logic [CHAR_W-1:0]      canvas_model [0:CANVAS_DEPTH-1];
    logic [CFG_DATA_W-1:0]  model_w  = 9'd256;
    logic [CFG_DATA_W-1:0]  model_h  = 9'd256;
    logic [CHAR_W-1:0]      model_bg = 8'd32;

    canvas_result_t         pending_results [$];
    directed_row_t          plan [$];
    bit                     no_stall   = 1'b0;
    int                     fail_count = 0;

    circle_canvas_painter_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #4 clk = ~clk;

    initial
    begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic canvas_result_t paint_canvas_model(input canvas_item_t it);
        canvas_result_t res;
        int             ew;
        int             eh;
        longint         cx;
        longint         cy;
        longint         rad;
        longint         outer;
        longint         inner;
        longint         dx;
        longint         dy;
        longint         d2;
        bit             has_inner;
        bit             filled;
        res.pix    = '0;
        res.status = STATUS_OK;
        ew = (model_w > MAX_SIDE) ? MAX_SIDE : int'(model_w);
        eh = (model_h > MAX_SIDE) ? MAX_SIDE : int'(model_h);
        case (it.kind)
            KIND_CLEAR:
            begin
                for (int c = 0; c < ew; c++)
                    for (int r = 0; r < eh; r++)
                        canvas_model[r * MAX_SIDE + c] = model_bg;
            end
            KIND_DRAW:
            begin
                cx  = it.cx;
                cy  = it.cy;
                rad = it.rad;
                if (rad <= 0 || (it.shape != SHAPE_OUTLINE && it.shape != SHAPE_FILLED))
                begin
                    res.status = STATUS_REJECT;
                end
                else
                begin
                    outer     = rad * rad;
                    has_inner = rad > FIX_ONE;
                    inner     = has_inner ? (rad - FIX_ONE) * (rad - FIX_ONE) : 0;
                    filled    = (it.shape == SHAPE_FILLED);
                    for (int c = 0; c < ew; c++)
                    begin
                        dx = (longint'(c) <<< FRAC_BITS) - cx;
                        for (int r = 0; r < eh; r++)
                        begin
                            dy = (longint'(r) <<< FRAC_BITS) - cy;
                            d2 = dx * dx + dy * dy;
                            // border band paints always, the inside only when filled
                            if (d2 <= outer && (!has_inner || d2 >= inner || filled))
                                canvas_model[r * MAX_SIDE + c] = it.paint;
                        end
                    end
                end
            end
            KIND_READ:
            begin
                if (it.col < ew && it.row < eh)
                    res.pix = canvas_model[{it.row, it.col}];
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic directed_row_t op_row(input logic [1:0] kind, input logic [7:0] shape,
                                             input int cx, input int cy, input int rad,
                                             input logic [7:0] paint, input logic [7:0] col,
                                             input logic [7:0] row);
        directed_row_t d;
        d.is_cfg      = 1'b0;
        d.reg_idx     = '0;
        d.reg_val     = '0;
        d.item.kind   = kind;
        d.item.shape  = shape;
        d.item.cx     = COORD_W'(cx);
        d.item.cy     = COORD_W'(cy);
        d.item.rad    = COORD_W'(rad);
        d.item.paint  = paint;
        d.item.col    = col;
        d.item.row    = row;
        d.typed       = 1'b0;
        d.want.pix    = '0;
        d.want.status = STATUS_OK;
        return d;
    endfunction

    function automatic directed_row_t checked_as(input directed_row_t d, input logic [7:0] pix,
                                                 input logic status);
        d.typed       = 1'b1;
        d.want.pix    = pix;
        d.want.status = status;
        return d;
    endfunction

    function automatic directed_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                              input logic [CFG_DATA_W-1:0] val);
        directed_row_t d;
        d = op_row(KIND_CLEAR, 8'h00, 0, 0, 0, 8'h00, 8'h00, 8'h00);
        d.is_cfg  = 1'b1;
        d.reg_idx = idx;
        d.reg_val = val;
        return d;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_side();
        case ($urandom_range(0, 9))
            0:       return 9'd0;
            1:       return 9'($urandom_range(257, 511));
            2:       return 9'd1;
            default: return 9'($urandom_range(2, 24));
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", what);
    endtask

    // drain the block, then write one register
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            CFG_WIDTH:  model_w  = val;
            CFG_HEIGHT: model_h  = val;
            CFG_BG:     model_bg = val[CHAR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send_item(input canvas_item_t it, input bit typed, input logic [7:0] want_pix,
                             input logic want_status);
        logic [IN_DATA_W-1:0] word;
        canvas_result_t       want;
        cfg_we <= 1'b0;
        if (!no_stall)
            while ($urandom_range(0, 99) < 11)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        word = '0;
        word[SHAPE_LSB +: 8]      = it.shape;
        word[CX_LSB +: COORD_W]   = it.cx;
        word[CY_LSB +: COORD_W]   = it.cy;
        word[RAD_LSB +: COORD_W]  = it.rad;
        word[PAINT_LSB +: CHAR_W] = it.paint;
        word[COL_LSB +: 8]        = it.col;
        word[ROW_LSB +: 8]        = it.row;
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= it.kind;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        want = paint_canvas_model(it);
        if (typed)
        begin
            want.pix    = want_pix;
            want.status = want_status;
        end
        pending_results.push_back(want);
    endtask

    // config, clear, then a random mix of clears, well-formed draws, reads and noise
    task automatic run_phase(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                             input logic [CHAR_W-1:0] bg, input int n);
        canvas_item_t it;
        int           ew;
        int           eh;
        int           pick;
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_BG, 9'(bg));
        ew = (w > MAX_SIDE) ? MAX_SIDE : int'(w);
        eh = (h > MAX_SIDE) ? MAX_SIDE : int'(h);
        for (int i = 0; i < n; i++)
        begin
            it.shape = 8'($urandom);
            it.cx    = COORD_W'($urandom);
            it.cy    = COORD_W'($urandom);
            it.rad   = COORD_W'($urandom);
            it.paint = 8'($urandom);
            it.col   = 8'($urandom);
            it.row   = 8'($urandom);
            pick     = (i == 0) ? 0 : int'($urandom_range(1, 100));
            if (pick == 0 || (pick > 85 && pick <= 90))
            begin
                it.kind = KIND_CLEAR;
            end
            else if (pick <= 45)
            begin
                it.kind  = KIND_DRAW;
                it.shape = $urandom_range(0, 1) ? SHAPE_FILLED : SHAPE_OUTLINE;
                it.cx    = COORD_W'(int'($urandom_range(0, (ew + 8) * FIX)) - 4 * FIX);
                it.cy    = COORD_W'(int'($urandom_range(0, (eh + 8) * FIX)) - 4 * FIX);
                if ($urandom_range(0, 3) == 0)
                    it.rad = COORD_W'($urandom_range(1, 2 * FIX));
                else
                    it.rad = COORD_W'($urandom_range(1, 12 * FIX));
            end
            else if (pick <= 85)
            begin
                it.kind = KIND_READ;
                if (ew > 0 && $urandom_range(0, 3) != 0)
                    it.col = 8'($urandom_range(0, ew - 1));
                if (eh > 0 && $urandom_range(0, 3) != 0)
                    it.row = 8'($urandom_range(0, eh - 1));
            end
            else if (pick <= 96)
            begin
                // random type byte, or a good type with a radius at or below zero
                it.kind = KIND_DRAW;
                if ($urandom_range(0, 1))
                begin
                    it.shape = $urandom_range(0, 1) ? SHAPE_FILLED : SHAPE_OUTLINE;
                    it.rad   = COORD_W'(-int'($urandom_range(0, 524288)));
                end
            end
            else
            begin
                it.kind = KIND_UNUSED;
            end
            send_item(it, 1'b0, 8'h00, STATUS_OK);
        end
    endtask

    initial
    begin : result_check
        canvas_result_t want;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected transfer: pixel_value %02h status %0d",
                                              m_tdata, m_tuser));
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (m_tdata !== want.pix)
                        report_mismatch($sformatf("pixel_value: expected %02h, got %02h",
                                                  want.pix, m_tdata));
                    if (m_tuser[0] !== want.status)
                        report_mismatch($sformatf("status: expected %0d, got %0d",
                                                  want.status, m_tuser[0]));
                end
            end
            m_tready <= no_stall || ($urandom_range(0, 99) >= 11);
        end
    end

    initial
    begin : stimulus
        logic [CFG_DATA_W-1:0] side_w;
        logic [CFG_DATA_W-1:0] side_h;
        canvas_item_t          it;

        // full canvas at reset settings; this clear writes every pixel once
        plan.push_back(checked_as(op_row(KIND_CLEAR, 8'h00, 0, 0, 0, 8'h00, 8'h00, 8'h00),
                                  8'h00, STATUS_OK));
        plan.push_back(checked_as(op_row(KIND_READ, 8'h00, 0, 0, 0, 8'h00, 8'h00, 8'h00),
                                  8'd32, STATUS_OK));
        plan.push_back(checked_as(op_row(KIND_READ, 8'h00, 0, 0, 0, 8'h00, 8'hFF, 8'hFF),
                                  8'd32, STATUS_OK));
        plan.push_back(reg_row(CFG_WIDTH, 9'd16));
        plan.push_back(reg_row(CFG_HEIGHT, 9'd12));
        plan.push_back(reg_row(CFG_BG, 9'h02E));
        plan.push_back(checked_as(op_row(KIND_CLEAR, 8'h00, 0, 0, 0, 8'h00, 8'h00, 8'h00),
                                  8'h00, STATUS_OK));
        plan.push_back(checked_as(op_row(KIND_READ, 8'h00, 0, 0, 0, 8'h00, 8'd15, 8'd11),
                                  8'h2E, STATUS_OK));
        // reads just past the used area
        plan.push_back(checked_as(op_row(KIND_READ, 8'h00, 0, 0, 0, 8'h00, 8'd16, 8'd0),
                                  8'h00, STATUS_OK));
        plan.push_back(checked_as(op_row(KIND_READ, 8'h00, 0, 0, 0, 8'h00, 8'd0, 8'd12),
                                  8'h00, STATUS_OK));
        plan.push_back(op_row(KIND_DRAW, SHAPE_OUTLINE, 8 * FIX, 6 * FIX, 5 * FIX, 8'h23, 0, 0));
        plan.push_back(op_row(KIND_DRAW, SHAPE_FILLED, 896, 1088, 960, 8'h2A, 0, 0));
        // rejected draws: radius zero, negative, most negative, bad type bytes
        plan.push_back(checked_as(op_row(KIND_DRAW, SHAPE_OUTLINE, 0, 0, 0, 8'h11, 0, 0),
                                  8'h00, STATUS_REJECT));
        plan.push_back(checked_as(op_row(KIND_DRAW, SHAPE_FILLED, 0, 0, -FIX, 8'h11, 0, 0),
                                  8'h00, STATUS_REJECT));
        plan.push_back(checked_as(op_row(KIND_DRAW, SHAPE_FILLED, 0, 0, -524288, 8'h11, 0, 0),
                                  8'h00, STATUS_REJECT));
        plan.push_back(checked_as(op_row(KIND_DRAW, 8'h00, 0, 0, 4 * FIX, 8'h11, 0, 0),
                                  8'h00, STATUS_REJECT));
        plan.push_back(checked_as(op_row(KIND_DRAW, 8'hFF, 0, 0, 4 * FIX, 8'h11, 0, 0),
                                  8'h00, STATUS_REJECT));
        // radius of one pixel: no inside, so filled paints like outline
        plan.push_back(op_row(KIND_DRAW, SHAPE_FILLED, 12 * FIX, 3 * FIX, FIX, 8'h6F, 0, 0));
        plan.push_back(op_row(KIND_DRAW, SHAPE_OUTLINE, -524288, 524287, 524287, 8'hFF, 0, 0));
        plan.push_back(checked_as(op_row(KIND_UNUSED, 8'hFF, -1, -1, -1, 8'hFF, 8'hFF, 8'hFF),
                                  8'h00, STATUS_OK));
        plan.push_back(op_row(KIND_READ, 8'h00, 0, 0, 0, 8'h00, 8'd8, 8'd1));
        plan.push_back(op_row(KIND_READ, 8'h00, 0, 0, 0, 8'h00, 8'd3, 8'd4));
        // empty canvas: nothing is in use
        plan.push_back(reg_row(CFG_WIDTH, 9'd0));
        plan.push_back(checked_as(op_row(KIND_CLEAR, 8'h00, 0, 0, 0, 8'h00, 8'h00, 8'h00),
                                  8'h00, STATUS_OK));
        plan.push_back(checked_as(op_row(KIND_DRAW, SHAPE_FILLED, 0, 0, 8 * FIX, 8'h40, 0, 0),
                                  8'h00, STATUS_OK));
        plan.push_back(checked_as(op_row(KIND_READ, 8'h00, 0, 0, 0, 8'h00, 8'd0, 8'd0),
                                  8'h00, STATUS_OK));
        // width saturates to the full side
        plan.push_back(reg_row(CFG_WIDTH, 9'd511));
        plan.push_back(reg_row(CFG_HEIGHT, 9'd1));
        plan.push_back(reg_row(CFG_BG, 9'h0FF));
        plan.push_back(checked_as(op_row(KIND_CLEAR, 8'h00, 0, 0, 0, 8'h00, 8'h00, 8'h00),
                                  8'h00, STATUS_OK));
        plan.push_back(checked_as(op_row(KIND_READ, 8'h00, 0, 0, 0, 8'h00, 8'd255, 8'd0),
                                  8'hFF, STATUS_OK));
        plan.push_back(op_row(KIND_DRAW, SHAPE_FILLED, 0, 0, 524287, 8'h00, 0, 0));
        plan.push_back(op_row(KIND_READ, 8'h00, 0, 0, 0, 8'h00, 8'd200, 8'd0));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            else
                send_item(plan[i].item, plan[i].typed, plan[i].want.pix, plan[i].want.status);
        end

        // random canvas sizes, at most one side large; one phase runs with no stalls on either side
        for (int p = 0; p < 8; p++)
        begin
            side_w = random_side();
            side_h = random_side();
            if (side_w > 24 && side_h > 24)
                side_h = 9'($urandom_range(1, 4));
            no_stall = (p == 3);
            run_phase(side_w, side_h, 8'($urandom), 8);
        end

        // full canvas: two draws, then reads anywhere
        no_stall = 1'b1;
        write_reg(CFG_WIDTH, 9'd256);
        write_reg(CFG_HEIGHT, 9'd256);
        write_reg(CFG_BG, 9'($urandom_range(0, 255)));
        for (int i = 0; i < 14; i++)
        begin
            it.kind  = (i < 2) ? KIND_DRAW : KIND_READ;
            it.shape = (i == 0) ? SHAPE_FILLED : SHAPE_OUTLINE;
            it.cx    = COORD_W'($urandom_range(0, 255 * FIX));
            it.cy    = COORD_W'($urandom_range(0, 255 * FIX));
            it.rad   = COORD_W'($urandom_range(FIX, 96 * FIX));
            it.paint = 8'($urandom);
            it.col   = 8'($urandom);
            it.row   = 8'($urandom);
            send_item(it, 1'b0, 8'h00, STATUS_OK);
        end
        s_tvalid <= 1'b0;
        no_stall = 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
